>>> design/pisc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisc_pkg: shared types and constants for the sector cylinder test
// Word layouts, internal datapath widths, register codes and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package pisc_pkg;

  // field widths fixed by the interface
  localparam int COORD_BITS = 16;
  localparam int VEC_W      = 16;
  localparam int CFG_W      = 48;
  localparam int CFG_IDX_W  = 3;

  // datapath widths
  localparam int DW   = COORD_BITS + 1;          // point minus origin
  localparam int PW   = DW + VEC_W;              // axis times offset
  localparam int SW   = PW + 2;                  // sum of three products
  localparam int AXW  = SW - 13;                 // rounded axial distance
  localparam int MW   = AXW + VEC_W;             // axial times axis
  localparam int DFW  = MW + 1;                  // radial difference before rounding
  localparam int RW   = DFW - 13;                // rounded radial component
  localparam int QW   = 2 * RW + 2;              // sum of squares
  localparam int SQRW = QW / 2;                  // square root result
  localparam int CRW  = 2 * VEC_W + 2 - 14;      // rounded cross product
  localparam int PVW  = RW + VEC_W;              // start times radial
  localparam int PCW  = RW + CRW;                // cross times radial
  localparam int XW   = PCW + 2;                 // CORDIC operands
  localparam int KW   = XW + 3;                  // CORDIC x/y with growth
  localparam int ZW   = 34;                      // angle in 2^-32 turn
  localparam int AGW  = 17;                      // clamped angle in 2^-16 turn
  localparam int BW   = AXW + 18;                // bound compare width

  localparam int GEO_LAT            = 7;
  localparam int CORDIC_STAGES_DFLT = 16;

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN = 3'd0,
    REG_AXIS   = 3'd1,
    REG_START  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_RADIUS = 3'd4,
    REG_ANGLE  = 3'd5,
    REG_TOL    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic               inside_res;
    logic        [15:0] radial_dist;
    logic signed [15:0] signed_angle;
    logic signed [15:0] axial_dist;
    logic               on_axis;
  } out_word_t;

  // geometry front end result
  typedef struct packed {
    logic        [QW-1:0]  sumsq;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [AXW-1:0] ax;
    logic                  on_axis;
  } geo_word_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] t;
    case (idx)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051D;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2E;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2F9;
      15: t = 32'h0000517C;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A2F;
      19: t = 32'h00000517;
      20: t = 32'h0000028B;
      21: t = 32'h00000145;
      22: t = 32'h000000A2;
      23: t = 32'h00000051;
      24: t = 32'h00000028;
      25: t = 32'h00000014;
      26: t = 32'h0000000A;
      27: t = 32'h00000005;
      28: t = 32'h00000002;
      29: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

>>> design/point_in_sector_cylinder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_sector_cylinder_test: sector cylinder membership test
// Projects each point onto a configured cylinder and tests its bounds.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready carry one point word (x, y, z in Q8.8); out_valid/
//    out_ready carry one result word per point, in order.
//  - cfg_wr_en writes cfg_wdata into register cfg_index; write only while
//    the block is empty. Unknown indexes are ignored.
//  - throughput: one word per cycle unless the receiver stalls; fully pipelined.
//  - the 27-stage square root, one root bit per stage, is deeper than the
//    CORDIC at the default and sets the pipeline depth.
//  - reset clears all valid bits and loads the register defaults.
//  - when the receiver stalls, the whole pipeline holds in place and
//    in_ready goes low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module point_in_sector_cylinder_test import pisc_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DFLT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SQ_LAT   = SQRW;
  localparam int CO_LAT   = CORDIC_STAGES + 2;
  localparam int UNIT_LAT = (SQ_LAT > CO_LAT) ? SQ_LAT : CO_LAT;
  localparam int VLAT     = GEO_LAT + UNIT_LAT;

  logic [CFG_W-1:0] origin_r, axis_r, start_r;
  logic [14:0]      height_r, radius_r;
  logic [15:0]      angle_r;
  logic [11:0]      tol_r;

  logic signed [CRW-1:0] cross_r [3];
  logic [31:0] ru_r, hu_r;
  logic [27:0] tp_r;
  logic [32:0] pu_r;
  logic [26:0] th_r;
  logic [16:0] u_sum;

  logic            vld_r [VLAT];
  logic            out_valid_r;
  out_word_t       out_word_r;
  logic            adv;

  geo_word_t             geo;
  logic [SQRW-1:0]       rad_u, rad_d;
  logic signed [AGW-1:0] ang_u, ang_d;
  logic [AXW:0]          side_d;
  logic signed [AXW-1:0] ax_d;
  logic                  axis_d;

  logic [SQRW+15:0]      rad_s;
  logic signed [BW-1:0]  ang_s, ax_s;
  logic                  in_sector;

  function automatic logic signed [CRW-1:0] cross_rnd(
    input logic signed [VEC_W-1:0] p,
    input logic signed [VEC_W-1:0] q,
    input logic signed [VEC_W-1:0] r,
    input logic signed [VEC_W-1:0] s
  );
    logic signed [2*VEC_W+1:0] t;
    t = (2*VEC_W+2)'(p) * (2*VEC_W+2)'(q) - (2*VEC_W+2)'(r) * (2*VEC_W+2)'(s)
      + (2*VEC_W+2)'(8192);
    return CRW'(t >>> 14);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      axis_r   <= 48'hC000_0000_0000;
      start_r  <= 48'h0000_4000_0000;
      height_r <= 15'd256;
      radius_r <= 15'd256;
      angle_r  <= 16'd16384;
      tol_r    <= 12'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN: origin_r <= cfg_wdata;
        REG_AXIS:   axis_r   <= cfg_wdata;
        REG_START:  start_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata[14:0];
        REG_RADIUS: radius_r <= cfg_wdata[14:0];
        REG_ANGLE:  angle_r  <= cfg_wdata[15:0];
        REG_TOL:    tol_r    <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // derived constants: axis x start, and the widened bounds
  assign u_sum = 17'd65536 + 17'(tol_r);

  always_ff @(posedge clk) begin
    cross_r[0] <= cross_rnd($signed(axis_r[31:16]), $signed(start_r[47:32]),
                            $signed(axis_r[47:32]), $signed(start_r[31:16]));
    cross_r[1] <= cross_rnd($signed(axis_r[47:32]), $signed(start_r[15:0]),
                            $signed(axis_r[15:0]),  $signed(start_r[47:32]));
    cross_r[2] <= cross_rnd($signed(axis_r[15:0]),  $signed(start_r[31:16]),
                            $signed(axis_r[31:16]), $signed(start_r[15:0]));
    ru_r <= 32'(radius_r) * 32'(u_sum);
    hu_r <= 32'(height_r) * 32'(u_sum);
    tp_r <= 28'(tol_r) * 28'(angle_r);
    pu_r <= 33'(angle_r) * 33'(u_sum);
    th_r <= 27'(tol_r) * 27'(height_r);
  end

  // pipeline advance and valid bits
  assign adv      = out_ready || !out_valid_r;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < VLAT; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < VLAT; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[VLAT-1];
    end
  end

  // datapath units
  pisc_geom u_geom (
    .clk       (clk),
    .adv       (adv),
    .pt        (in_word),
    .origin    (origin_r),
    .axis_dir  (axis_r),
    .start_dir (start_r),
    .cross_dir (cross_r),
    .geo       (geo)
  );

  pisc_sqrt u_sqrt (
    .clk  (clk),
    .adv  (adv),
    .val  (geo.sumsq),
    .root (rad_u)
  );

  pisc_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk   (clk),
    .adv   (adv),
    .x_in  (geo.x),
    .y_in  (geo.y),
    .angle (ang_u)
  );

  // align the parallel paths
  pisc_delay #(.W(AXW + 1), .DEPTH(UNIT_LAT)) u_dly_side (
    .clk  (clk),
    .adv  (adv),
    .din  ({geo.ax, geo.on_axis}),
    .dout (side_d)
  );

  pisc_delay #(.W(SQRW), .DEPTH(UNIT_LAT - SQ_LAT)) u_dly_rad (
    .clk  (clk),
    .adv  (adv),
    .din  (rad_u),
    .dout (rad_d)
  );

  pisc_delay #(.W(AGW), .DEPTH(UNIT_LAT - CO_LAT)) u_dly_ang (
    .clk  (clk),
    .adv  (adv),
    .din  (ang_u),
    .dout (ang_d)
  );

  assign ax_d   = $signed(side_d[AXW:1]);
  assign axis_d = side_d[0];

  // bound tests against the widened limits
  assign rad_s = {rad_d, 16'b0};
  assign ang_s = BW'(ang_d) <<< 16;
  assign ax_s  = BW'(ax_d) <<< 16;

  assign in_sector = !axis_d
                  && (rad_s < (SQRW+16)'(ru_r))
                  && (ang_s > -$signed(BW'(tp_r)))
                  && (ang_s < $signed(BW'(pu_r)))
                  && (ax_s > -$signed(BW'(th_r)))
                  && (ax_s < $signed(BW'(hu_r)));

  // output register with saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r.inside_res   <= in_sector;
      out_word_r.radial_dist  <= (|rad_d[SQRW-1:16]) ? 16'hFFFF : rad_d[15:0];
      out_word_r.signed_angle <= (ang_d > AGW'(32767)) ? 16'sh7FFF : ang_d[15:0];
      if (ax_d > AXW'(32767)) out_word_r.axial_dist <= 16'sh7FFF;
      else if (ax_d < AXW'(-32768)) out_word_r.axial_dist <= 16'sh8000;
      else out_word_r.axial_dist <= ax_d[15:0];
      out_word_r.on_axis <= axis_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // an on-axis point is never inside and carries a zero angle
  a_on_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.on_axis |-> !out_word.inside_res && out_word.signed_angle == 0)
    else $error("on-axis word reported inside or with nonzero angle");

  // square root and geometry paths stay aligned
  a_rad_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_word.radial_dist == 0) == out_word.on_axis))
    else $error("radial distance and on-axis flag disagree");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

endmodule

>>> design/pisc_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisc_delay: stallable alignment delay line
// Passes a word through DEPTH stallable registers so parallel units line up.
// ----------------------------------------------------------------------------
module pisc_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  if (DEPTH == 0) begin : g_none
    assign dout = din;
  end else begin : g_line
    logic [W-1:0] sh_r [DEPTH];

    // shift on every advance
    always_ff @(posedge clk) begin
      if (adv) begin
        sh_r[0] <= din;
        for (int k = 1; k < DEPTH; k++) sh_r[k] <= sh_r[k-1];
      end
    end

    assign dout = sh_r[DEPTH-1];
  end

endmodule

>>> design/pisc_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisc_geom: cylindrical projection front end
// Seven stages: offset, axial dot product, rounding, radial vector, then
// squares and angle operands, then their sums.
// ----------------------------------------------------------------------------
module pisc_geom import pisc_pkg::*; (
  input  logic                  clk,
  input  logic                  adv,
  input  in_word_t              pt,
  input  logic [CFG_W-1:0]      origin,
  input  logic [CFG_W-1:0]      axis_dir,
  input  logic [CFG_W-1:0]      start_dir,
  input  logic signed [CRW-1:0] cross_dir [3],
  output geo_word_t             geo
);

  logic signed [VEC_W-1:0] org [3];
  logic signed [VEC_W-1:0] a   [3];
  logic signed [VEC_W-1:0] v   [3];
  logic signed [VEC_W-1:0] pin [3];

  logic signed [DW-1:0]  d1_r [3];
  logic signed [DW-1:0]  d2_r [3];
  logic signed [DW-1:0]  d3_r [3];
  logic signed [DW-1:0]  d4_r [3];
  logic signed [PW-1:0]  pa2_r [3];
  logic signed [AXW-1:0] ax3_r, ax4_r, ax5_r, ax6_r;
  logic signed [MW-1:0]  m4_r [3];
  logic signed [RW-1:0]  r5_r [3];
  logic signed [2*RW-1:0] sq6_r [3];
  logic signed [PVW-1:0] pv6_r [3];
  logic signed [PCW-1:0] pc6_r [3];
  logic                  axis6_r;
  geo_word_t             geo_r;

  logic signed [SW-1:0]  asum, arnd;
  logic signed [DFW-1:0] diff [3];
  logic signed [DFW-1:0] drnd [3];

  // unpack vector fields, x lowest
  always_comb begin
    pin[0] = pt.point_x;
    pin[1] = pt.point_y;
    pin[2] = pt.point_z;
    for (int k = 0; k < 3; k++) begin
      org[k] = $signed(origin[VEC_W*k +: VEC_W]);
      a[k]   = $signed(axis_dir[VEC_W*k +: VEC_W]);
      v[k]   = $signed(start_dir[VEC_W*k +: VEC_W]);
    end
  end

  // axial sum rounded half up, radial components rounded half up
  always_comb begin
    asum = SW'(pa2_r[0]) + SW'(pa2_r[1]) + SW'(pa2_r[2]);
    arnd = asum + SW'(8192);
    for (int k = 0; k < 3; k++) begin
      diff[k] = (DFW'(d4_r[k]) <<< 14) - DFW'(m4_r[k]);
      drnd[k] = diff[k] + DFW'(8192);
    end
  end

  // pipeline stages; radial magnitude stays far below 2^30 so no clamp
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k]  <= DW'(pin[k]) - DW'(org[k]);
        pa2_r[k] <= PW'(a[k]) * PW'(d1_r[k]);
        d2_r[k]  <= d1_r[k];
        d3_r[k]  <= d2_r[k];
        m4_r[k]  <= MW'(ax3_r) * MW'(a[k]);
        d4_r[k]  <= d3_r[k];
        r5_r[k]  <= RW'(drnd[k] >>> 14);
        sq6_r[k] <= (2*RW)'(r5_r[k]) * (2*RW)'(r5_r[k]);
        pv6_r[k] <= PVW'(v[k]) * PVW'(r5_r[k]);
        pc6_r[k] <= PCW'(cross_dir[k]) * PCW'(r5_r[k]);
      end
      ax3_r   <= AXW'(arnd >>> 14);
      ax4_r   <= ax3_r;
      ax5_r   <= ax4_r;
      ax6_r   <= ax5_r;
      axis6_r <= (r5_r[0] == '0) && (r5_r[1] == '0) && (r5_r[2] == '0);
      geo_r.sumsq   <= QW'($unsigned(sq6_r[0])) + QW'($unsigned(sq6_r[1]))
                     + QW'($unsigned(sq6_r[2]));
      geo_r.x       <= XW'(pv6_r[0]) + XW'(pv6_r[1]) + XW'(pv6_r[2]);
      geo_r.y       <= XW'(pc6_r[0]) + XW'(pc6_r[1]) + XW'(pc6_r[2]);
      geo_r.ax      <= ax6_r;
      geo_r.on_axis <= axis6_r;
    end
  end

  assign geo = geo_r;

endmodule

>>> design/pisc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisc_sqrt: pipelined floor square root
// Restoring method, one root bit per stage, SQRW stages.
// ----------------------------------------------------------------------------
module pisc_sqrt import pisc_pkg::*; (
  input  logic            clk,
  input  logic            adv,
  input  logic [QW-1:0]   val,
  output logic [SQRW-1:0] root
);

  logic [QW-1:0]   val_r  [SQRW];
  logic [SQRW+1:0] rem_r  [SQRW];
  logic [SQRW-1:0] root_r [SQRW];

  for (genvar s = 0; s < SQRW; s++) begin : g_stage
    logic [QW-1:0]   val_in;
    logic [SQRW+1:0] rem_in;
    logic [SQRW-1:0] root_in;
    logic [SQRW+1:0] rem_sh, trial;

    if (s == 0) begin : g_first
      assign val_in  = val;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign val_in  = val_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    // bring down two bits, try the next root bit
    assign rem_sh = {rem_in[SQRW-1:0], val_in[QW-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (adv) begin
        val_r[s] <= val_in << 2;
        if (rem_sh >= trial) begin
          rem_r[s]  <= rem_sh - trial;
          root_r[s] <= {root_in[SQRW-2:0], 1'b1};
        end else begin
          rem_r[s]  <= rem_sh;
          root_r[s] <= {root_in[SQRW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[SQRW-1];

endmodule

>>> design/pisc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisc_cordic: pipelined vectoring CORDIC
// Quadrant fold, CORDIC_STAGES micro-rotations, then rounding to 2^-16 turn.
// ----------------------------------------------------------------------------
module pisc_cordic import pisc_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DFLT
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic signed [XW-1:0]  x_in,
  input  logic signed [XW-1:0]  y_in,
  output logic signed [AGW-1:0] angle
);

  localparam logic signed [ZW-1:0]  QUARTER = ZW'(1073741824);
  localparam logic signed [ZW:0]    ANG_HI  = (ZW+1)'(32768);
  localparam logic signed [ZW:0]    ANG_LO  = (ZW+1)'(-32768);

  logic signed [KW-1:0]  x_r [CORDIC_STAGES+1];
  logic signed [KW-1:0]  y_r [CORDIC_STAGES+1];
  logic signed [ZW-1:0]  z_r [CORDIC_STAGES+1];
  logic signed [KW-1:0]  xe, ye;
  logic signed [ZW:0]    zr, zq;
  logic signed [AGW-1:0] angle_r;

  assign xe = KW'(x_in);
  assign ye = KW'(y_in);

  // fold the left half plane by a quarter turn
  always_ff @(posedge clk) begin
    if (adv) begin
      if (xe < 0) begin
        if (ye >= 0) begin
          x_r[0] <= ye;
          y_r[0] <= -xe;
          z_r[0] <= QUARTER;
        end else begin
          x_r[0] <= -ye;
          y_r[0] <= xe;
          z_r[0] <= -QUARTER;
        end
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
    end
  end

  // micro-rotations; a zero y stops the walk and is passed through
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_turn(i));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end else if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  // round half up to 2^-16 turn and clamp to a half turn
  assign zr = (ZW+1)'(z_r[CORDIC_STAGES]) + (ZW+1)'(32768);
  assign zq = zr >>> 16;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zq > ANG_HI) angle_r <= AGW'(ANG_HI);
      else if (zq < ANG_LO) angle_r <= AGW'(ANG_LO);
      else angle_r <= AGW'(zq);
    end
  end

  assign angle = angle_r;

endmodule
